### hdl/etr_pkg.sv
// ----------------------------------------------------------------------------
// etr_pkg: shared constants, types and tables
// Emotion codes, the byte class map, the transition table and the keyword list
// for the emoticon token recognizer.
// ----------------------------------------------------------------------------
package etr_pkg;

    localparam int MAX_LEN_DEF = 4096;
    localparam int WIN_DEPTH   = 9;
    localparam int OFF_W       = 13;
    localparam int KW_COUNT    = 14;

    localparam logic [4:0] EMO_SMILE    = 5'd0;
    localparam logic [4:0] EMO_FROWN    = 5'd1;
    localparam logic [4:0] EMO_NEUTRAL  = 5'd2;
    localparam logic [4:0] EMO_GRIN     = 5'd3;
    localparam logic [4:0] EMO_GLEEFUL  = 5'd4;
    localparam logic [4:0] EMO_WINK     = 5'd5;
    localparam logic [4:0] EMO_CONFUSE  = 5'd6;
    localparam logic [4:0] EMO_SHOCK    = 5'd7;
    localparam logic [4:0] EMO_GRUMPY   = 5'd8;
    localparam logic [4:0] EMO_UPSET    = 5'd9;
    localparam logic [4:0] EMO_CRY      = 5'd10;
    localparam logic [4:0] EMO_SURPRISE = 5'd11;
    localparam logic [4:0] EMO_RED      = 5'd12;
    localparam logic [4:0] EMO_EEK      = 5'd13;
    localparam logic [4:0] EMO_YELL     = 5'd14;
    localparam logic [4:0] EMO_ROLL     = 5'd15;
    localparam logic [4:0] EMO_BLINK    = 5'd16;
    localparam logic [4:0] EMO_SWEAT    = 5'd17;
    localparam logic [4:0] EMO_RAZZ     = 5'd18;
    localparam logic [4:0] EMO_SLEEP    = 5'd19;
    localparam logic [4:0] EMO_SAINT    = 5'd20;
    localparam logic [4:0] EMO_EVIL     = 5'd21;
    localparam logic [4:0] EMO_COOL     = 5'd22;
    localparam logic [4:0] EMO_GLASSES  = 5'd23;
    localparam logic [4:0] EMO_KISS     = 5'd24;
    localparam logic [4:0] EMO_KITTY    = 5'd25;

    typedef struct packed {
        logic       fin;
        logic [4:0] emo;
    } scan_ctl_t;

    // keyword text, first character in the top byte, zero padded to 9 bytes
    localparam logic [71:0] KW_TXT [KW_COUNT] = '{
        {":angel:", 16'h0}, {":cool:", 24'h0}, {":grin:", 24'h0},
        {":lol:", 32'h0}, ":neutral:", {":oops:", 24'h0},
        {":wunk:", 24'h0}, {":zzz:", 32'h0}, {":roll:", 24'h0},
        {":sad:", 32'h0}, {":shock:", 16'h0}, {":smile:", 16'h0},
        {":eek:", 32'h0}, {":evil:", 24'h0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd6, 4'd6, 4'd5, 4'd9, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd7, 4'd7,
        4'd5, 4'd6
    };
    localparam logic [4:0] KW_CODE [KW_COUNT] = '{
        EMO_SAINT, EMO_COOL, EMO_GRIN, EMO_GLEEFUL, EMO_NEUTRAL, EMO_SURPRISE,
        EMO_WINK, EMO_SLEEP, EMO_ROLL, EMO_FROWN, EMO_SHOCK, EMO_SMILE,
        EMO_EEK, EMO_EVIL
    };

    function automatic logic signed [7:0] acc(input logic [4:0] e);
        return -$signed({3'b000, e}) - 8'sd1;
    endfunction

    function automatic logic [4:0] acc_code(input logic signed [7:0] v);
        logic signed [7:0] t;
        t = -v - 8'sd1;
        return t[4:0];
    endfunction

    function automatic logic [5:0] byte_class(input logic [7:0] b);
        logic [5:0] c;
        case (b)
            8'h25: c = 6'd1;   8'h27: c = 6'd2;   8'h28: c = 6'd3;   8'h29: c = 6'd4;
            8'h2A: c = 6'd5;   8'h2D: c = 6'd6;   8'h2E: c = 6'd7;   8'h2F: c = 6'd8;
            8'h30: c = 6'd9;   8'h33: c = 6'd10;  8'h38: c = 6'd11;  8'h3A: c = 6'd12;
            8'h3B: c = 6'd13;  8'h3C: c = 6'd14;  8'h3D: c = 6'd15;  8'h3E: c = 6'd16;
            8'h3F: c = 6'd17;  8'h40: c = 6'd18;  8'h42: c = 6'd19;  8'h43: c = 6'd20;
            8'h44: c = 6'd21;  8'h49: c = 6'd22;  8'h4C: c = 6'd23;  8'h4F: c = 6'd24;
            8'h50: c = 6'd25;  8'h53: c = 6'd26;  8'h58: c = 6'd27;  8'h5B: c = 6'd28;
            8'h5C: c = 6'd29;  8'h5D: c = 6'd30;  8'h5E: c = 6'd31;  8'h5F: c = 6'd32;
            8'h63: c = 6'd33;  8'h6F: c = 6'd34;  8'h73: c = 6'd35;  8'h7C: c = 6'd36;
            8'h7E: c = 6'd37;
            default: c = 6'd0;
        endcase
        return c;
    endfunction

    // negative result: accept, emotion code is -v-1; zero: no arc
    function automatic logic signed [7:0] rom(input logic [6:0] st, input logic [5:0] sym);
        logic signed [7:0] r;
        r = 8'sd0;
        if (st == 7'd0)
        begin
            r = $signed({2'b00, sym});
        end
        else
        begin
            case ({st, sym})
                {7'd1,6'd6}: r = acc(EMO_ROLL);   {7'd1,6'd24}: r = 8'sd47;
                {7'd2,6'd6}: r = 8'sd38;          {7'd2,6'd32}: r = 8'sd39;
                {7'd3,6'd31}: r = 8'sd40;
                {7'd9,6'd9}: r = 8'sd73;  {7'd9,6'd12}: r = 8'sd47;  {7'd9,6'd15}: r = 8'sd49;
                {7'd11,6'd6}: r = 8'sd49; {7'd11,6'd15}: r = 8'sd49;
                {7'd12,6'd2}: r = 8'sd51; {7'd12,6'd3}: r = 8'sd53; {7'd12,6'd4}: r = 8'sd54;
                {7'd12,6'd5}: r = acc(EMO_KISS); {7'd12,6'd6}: r = 8'sd50;
                {7'd12,6'd12}: r = 8'sd55; {7'd12,6'd15}: r = 8'sd50;
                {7'd12,6'd17}: r = acc(EMO_CONFUSE); {7'd12,6'd22}: r = acc(EMO_NEUTRAL);
                {7'd12,6'd36}: r = acc(EMO_NEUTRAL);
                {7'd13,6'd4}: r = acc(EMO_WINK); {7'd13,6'd6}: r = 8'sd57;
                {7'd13,6'd15}: r = 8'sd57;
                {7'd15,6'd2}: r = 8'sd58; {7'd15,6'd3}: r = acc(EMO_FROWN);
                {7'd15,6'd5}: r = acc(EMO_KISS); {7'd15,6'd6}: r = 8'sd59;
                {7'd15,6'd17}: r = acc(EMO_CONFUSE); {7'd15,6'd19}: r = 8'sd60;
                {7'd15,6'd22}: r = acc(EMO_NEUTRAL); {7'd15,6'd36}: r = acc(EMO_NEUTRAL);
                {7'd16,6'd12}: r = 8'sd61; {7'd16,6'd15}: r = 8'sd62;
                {7'd18,6'd31}: r = 8'sd65; {7'd19,6'd6}: r = 8'sd68; {7'd19,6'd15}: r = 8'sd68;
                {7'd20,6'd12}: r = 8'sd69; {7'd20,6'd15}: r = 8'sd69;
                {7'd21,6'd6}: r = 8'sd71; {7'd22,6'd6}: r = 8'sd72; {7'd24,6'd32}: r = 8'sd74;
                {7'd27,6'd6}: r = 8'sd75; {7'd29,6'd15}: r = 8'sd76; {7'd31,6'd31}: r = 8'sd81;
                {7'd33,6'd28}: r = 8'sd82; {7'd34,6'd32}: r = 8'sd83;
                {7'd37,6'd6}: r = 8'sd84; {7'd37,6'd7}: r = 8'sd84;
                {7'd38,6'd4}: r = acc(EMO_WINK); {7'd39,6'd2}: r = acc(EMO_SHOCK);
                {7'd40,6'd15}: r = 8'sd44; {7'd40,6'd32}: r = 8'sd41;
                {7'd41,6'd31}: r = 8'sd42; {7'd42,6'd14}: r = 8'sd43;
                {7'd43,6'd4}: r = acc(EMO_SWEAT); {7'd44,6'd32}: r = 8'sd45;
                {7'd45,6'd15}: r = 8'sd46; {7'd46,6'd4}: r = acc(EMO_SLEEP);
                {7'd47,6'd4}: r = acc(EMO_SAINT); {7'd47,6'd6}: r = 8'sd48;
                {7'd48,6'd4}: r = acc(EMO_SAINT);
                {7'd49,6'd4}: r = acc(EMO_GLASSES); {7'd49,6'd9}: r = acc(EMO_EEK);
                {7'd49,6'd22}: r = acc(EMO_ROLL); {7'd49,6'd24}: r = acc(EMO_EEK);
                {7'd50,6'd3}: r = acc(EMO_FROWN); {7'd50,6'd4}: r = acc(EMO_SMILE);
                {7'd50,6'd5}: r = acc(EMO_KISS); {7'd50,6'd8}: r = acc(EMO_CONFUSE);
                {7'd50,6'd9}: r = acc(EMO_SURPRISE); {7'd50,6'd10}: r = acc(EMO_KITTY);
                {7'd50,6'd14}: r = acc(EMO_GRUMPY); {7'd50,6'd17}: r = acc(EMO_CONFUSE);
                {7'd50,6'd18}: r = acc(EMO_UPSET); {7'd50,6'd22}: r = acc(EMO_NEUTRAL);
                {7'd50,6'd23}: r = acc(EMO_GRUMPY); {7'd50,6'd24}: r = acc(EMO_SURPRISE);
                {7'd50,6'd25}: r = acc(EMO_RAZZ); {7'd50,6'd26}: r = acc(EMO_GRUMPY);
                {7'd50,6'd34}: r = acc(EMO_SURPRISE); {7'd50,6'd35}: r = acc(EMO_CONFUSE);
                {7'd50,6'd36}: r = acc(EMO_NEUTRAL);
                {7'd51,6'd3}: r = acc(EMO_CRY); {7'd51,6'd6}: r = 8'sd52;
                {7'd52,6'd3}: r = acc(EMO_CRY);
                {7'd53,6'd0}: r = acc(EMO_FROWN); {7'd53,6'd3}: r = acc(EMO_CRY);
                {7'd54,6'd0}: r = acc(EMO_SMILE); {7'd54,6'd4}: r = acc(EMO_YELL);
                {7'd55,6'd6}: r = 8'sd56; {7'd56,6'd4}: r = acc(EMO_GLASSES);
                {7'd57,6'd4}: r = acc(EMO_WINK); {7'd57,6'd21}: r = acc(EMO_WINK);
                {7'd57,6'd30}: r = acc(EMO_GRIN); {7'd58,6'd3}: r = acc(EMO_CRY);
                {7'd59,6'd3}: r = acc(EMO_FROWN); {7'd59,6'd5}: r = acc(EMO_KISS);
                {7'd59,6'd17}: r = acc(EMO_CONFUSE); {7'd59,6'd22}: r = acc(EMO_NEUTRAL);
                {7'd59,6'd24}: r = acc(EMO_SURPRISE); {7'd59,6'd25}: r = acc(EMO_RAZZ);
                {7'd59,6'd26}: r = acc(EMO_GRUMPY); {7'd59,6'd34}: r = acc(EMO_SURPRISE);
                {7'd59,6'd36}: r = acc(EMO_NEUTRAL); {7'd60,6'd4}: r = acc(EMO_COOL);
                {7'd61,6'd3}: r = acc(EMO_UPSET); {7'd61,6'd4}: r = acc(EMO_EVIL);
                {7'd61,6'd6}: r = 8'sd63; {7'd61,6'd21}: r = acc(EMO_GLEEFUL);
                {7'd62,6'd3}: r = acc(EMO_UPSET); {7'd62,6'd4}: r = acc(EMO_EVIL);
                {7'd62,6'd16}: r = acc(EMO_EVIL); {7'd62,6'd21}: r = acc(EMO_EVIL);
                {7'd63,6'd3}: r = acc(EMO_UPSET); {7'd63,6'd4}: r = acc(EMO_EVIL);
                {7'd63,6'd6}: r = 8'sd64; {7'd63,6'd21}: r = acc(EMO_EVIL);
                {7'd64,6'd3}: r = acc(EMO_UPSET); {7'd64,6'd4}: r = acc(EMO_EVIL);
                {7'd64,6'd21}: r = acc(EMO_EVIL);
                {7'd65,6'd6}: r = 8'sd66; {7'd66,6'd31}: r = 8'sd67;
                {7'd67,6'd18}: r = acc(EMO_RED); {7'd68,6'd4}: r = acc(EMO_COOL);
                {7'd69,6'd4}: r = acc(EMO_SAINT); {7'd69,6'd6}: r = 8'sd70;
                {7'd70,6'd4}: r = acc(EMO_SAINT); {7'd71,6'd12}: r = acc(EMO_UPSET);
                {7'd71,6'd15}: r = acc(EMO_UPSET); {7'd72,6'd4}: r = acc(EMO_SLEEP);
                {7'd73,6'd9}: r = acc(EMO_EEK); {7'd74,6'd24}: r = acc(EMO_EEK);
                {7'd75,6'd3}: r = acc(EMO_UPSET); {7'd75,6'd21}: r = acc(EMO_YELL);
                {7'd76,6'd34}: r = 8'sd77; {7'd77,6'd6}: r = 8'sd78;
                {7'd78,6'd34}: r = 8'sd79; {7'd79,6'd15}: r = 8'sd80;
                {7'd80,6'd8}: r = acc(EMO_GLASSES);
                {7'd81,6'd13}: r = acc(EMO_SWEAT); {7'd82,6'd15}: r = acc(EMO_RAZZ);
                {7'd83,6'd34}: r = acc(EMO_NEUTRAL); {7'd84,6'd37}: r = acc(EMO_BLINK);
                default: r = 8'sd0;
            endcase
        end
        return r;
    endfunction

endpackage

### hdl/etr_scan.sv
// ----------------------------------------------------------------------------
// etr_scan: one scan step at the head of the lookahead window
// Tries the keywords first, then steps the class map and transition table.
// ----------------------------------------------------------------------------
module etr_scan #(
    parameter int PW = 13
) (
    input  logic [7:0]          win [etr_pkg::WIN_DEPTH],
    input  logic [3:0]          avail,
    input  logic [PW-1:0]       idx,
    input  logic [6:0]          st,
    input  logic [PW-1:0]       mstart,
    input  logic                done,
    output logic [6:0]          st_next,
    output logic [PW-1:0]       mstart_next,
    output etr_pkg::scan_ctl_t  ctl,
    output logic [PW-1:0]       end_off
);

    logic              kw_hit;
    logic [4:0]        kw_code;
    logic [3:0]        kw_len;
    logic [5:0]        sym;
    logic signed [7:0] hold;
    logic signed [7:0] nx;
    logic              eq;

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_code = etr_pkg::EMO_SMILE;
        kw_len  = 4'd0;
        // walk downward so the earliest keyword in the list wins
        for (int k = etr_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            eq = (etr_pkg::KW_LEN[k] <= avail);
            for (int j = 0; j < etr_pkg::WIN_DEPTH; j++)
            begin
                if (4'(j) < etr_pkg::KW_LEN[k] &&
                    win[j] != etr_pkg::KW_TXT[k][71 - 8*j -: 8])
                begin
                    eq = 1'b0;
                end
            end
            if (eq)
            begin
                kw_hit  = 1'b1;
                kw_code = etr_pkg::KW_CODE[k];
                kw_len  = etr_pkg::KW_LEN[k];
            end
        end
    end

    assign sym  = etr_pkg::byte_class(win[0]);
    assign hold = etr_pkg::rom(st, 6'd0);
    assign nx   = etr_pkg::rom(st, sym);

    always_comb
    begin
        st_next     = st;
        mstart_next = mstart;
        ctl.fin     = 1'b0;
        ctl.emo     = etr_pkg::EMO_SMILE;
        end_off     = idx;
        if (!done)
        begin
            if (kw_hit)
            begin
                ctl.fin     = 1'b1;
                ctl.emo     = kw_code;
                mstart_next = idx;
                end_off     = idx + PW'(kw_len);
            end
            else if (sym == 6'd0)
            begin
                if (st != 7'd0 && hold < 0)
                begin
                    ctl.fin = 1'b1;
                    ctl.emo = etr_pkg::acc_code(hold);
                end
                else
                begin
                    st_next = 7'd0;
                end
            end
            else if (nx < 0)
            begin
                ctl.fin = 1'b1;
                ctl.emo = etr_pkg::acc_code(nx);
                end_off = idx + PW'(1);
            end
            else if (nx == 0 && st != 7'd0 && hold < 0)
            begin
                // pending accept cut off by a byte that does not continue it
                ctl.fin = 1'b1;
                ctl.emo = etr_pkg::acc_code(hold);
            end
            else
            begin
                if (nx > 0 && st == 7'd0)
                begin
                    mstart_next = idx;
                end
                st_next = nx[6:0];
            end
        end
    end

endmodule

### hdl/emoticon_token_recognizer.sv
// ----------------------------------------------------------------------------
// emoticon_token_recognizer: finds the first emoticon in a text buffer
// Keyword compare over a 9-byte lookahead window, else class map and
// transition table; one result beat per buffer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                   | side
//  s_axis  | in  | text_byte[7:0]; tlast = last_byte           | one byte per beat
//  m_axis  | out | found, emotion_code[5:1], start_offset[18:6], | one beat per buffer
//          |     | end_offset[31:19]                           |
//
//  One byte is taken every cycle outside the drain; the scan of the window
//  head is registered. After the tlast beat, s_axis_tready drops while the
//  window drains the bytes still in it (up to 9) and then loads the result.
//  The result sits in an output register, so a new buffer may stream in while
//  it waits; the drain end stalls only if that register is still occupied.
//  Reset (rst_n low, asynchronous) clears the window and scan state.
module emoticon_token_recognizer #(
    parameter int MAX_LEN = etr_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [31:0] m_axis_tdata,   // found, emotion_code, start_offset, end_offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int XW = (PW > etr_pkg::OFF_W) ? PW : etr_pkg::OFF_W;
    localparam int WD = etr_pkg::WIN_DEPTH;

    logic [7:0]    win_reg [WD];
    logic [7:0]    win_next [WD];
    logic [3:0]    n_reg, n_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [6:0]    st_reg, st_next;
    logic [PW-1:0] ms_reg, ms_next;
    logic          done_reg, done_next;
    logic [4:0]    emo_reg, emo_next;
    logic [PW-1:0] end_reg, end_next;
    logic          drain_reg, drain_next;
    logic          ovalid_reg, ovalid_next;
    logic [31:0]   odata_reg, odata_next;

    logic          beat, app, finalize, scan_go;
    logic [7:0]    w_app [WD];
    logic [7:0]    w_src [WD];
    logic [3:0]    n1, sc_avail;
    logic [PW-1:0] pos1, sc_idx;
    logic [6:0]    sc_st;
    logic [PW-1:0] sc_ms, sc_end;
    etr_pkg::scan_ctl_t sc_ctl;
    logic signed [7:0]  hold_f;
    logic          f_found;
    logic [4:0]    f_emo;
    logic [PW-1:0] f_start, f_end;

    function automatic logic [etr_pkg::OFF_W-1:0] to_off(input logic [PW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[etr_pkg::OFF_W-1:0];
    endfunction

    assign s_axis_tready = !drain_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign app           = (pos_reg < PW'(MAX_LEN)) && (n_reg < 4'(WD));
    assign n1            = n_reg + {3'b000, app};
    assign pos1          = pos_reg + PW'(app);

    always_comb
    begin
        for (int j = 0; j < WD; j++)
        begin
            w_app[j] = win_reg[j];
        end
        if (app)
        begin
            w_app[n_reg] = s_axis_tdata;
        end
    end

    always_comb
    begin
        for (int j = 0; j < WD; j++)
        begin
            w_src[j] = drain_reg ? win_reg[j] : w_app[j];
        end
        sc_avail = drain_reg ? n_reg : 4'(WD);
        sc_idx   = drain_reg ? (pos_reg - PW'(n_reg)) : (pos1 - PW'(WD));
    end

    etr_scan #(.PW(PW)) u_scan (
        .win         (w_src),
        .avail       (sc_avail),
        .idx         (sc_idx),
        .st          (st_reg),
        .mstart      (ms_reg),
        .done        (done_reg),
        .st_next     (sc_st),
        .mstart_next (sc_ms),
        .ctl         (sc_ctl),
        .end_off     (sc_end)
    );

    // close-out of the buffer: a pending accept still open at the end counts
    always_comb
    begin
        hold_f  = etr_pkg::rom(st_reg, 6'd0);
        f_found = done_reg || (st_reg != 7'd0 && hold_f < 0);
        f_emo   = done_reg ? emo_reg : etr_pkg::acc_code(hold_f);
        f_start = ms_reg;
        f_end   = done_reg ? end_reg : pos_reg;
        if (!f_found)
        begin
            f_emo   = etr_pkg::EMO_SMILE;
            f_start = pos_reg;
            f_end   = pos_reg;
        end
    end

    assign finalize = drain_reg && (n_reg == 4'd0) && (!ovalid_reg || m_axis_tready);
    assign scan_go  = (beat && !s_axis_tlast && n1 == 4'(WD)) ||
                      (drain_reg && n_reg != 4'd0);

    always_comb
    begin
        for (int j = 0; j < WD; j++)
        begin
            win_next[j] = win_reg[j];
        end
        n_next      = n_reg;
        pos_next    = pos_reg;
        st_next     = st_reg;
        ms_next     = ms_reg;
        done_next   = done_reg;
        emo_next    = emo_reg;
        end_next    = end_reg;
        drain_next  = drain_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;

        if (beat)
        begin
            pos_next = pos1;
            n_next   = n1;
            for (int j = 0; j < WD; j++)
            begin
                win_next[j] = w_app[j];
            end
            if (s_axis_tlast)
            begin
                drain_next = 1'b1;
            end
        end

        if (scan_go)
        begin
            // advance the head: shift the window down by one
            for (int j = 0; j < WD - 1; j++)
            begin
                win_next[j] = w_src[j + 1];
            end
            win_next[WD-1] = 8'h00;
            n_next  = (drain_reg ? n_reg : n1) - 4'd1;
            st_next = sc_st;
            ms_next = sc_ms;
            if (sc_ctl.fin)
            begin
                done_next = 1'b1;
                emo_next  = sc_ctl.emo;
                end_next  = sc_end;
            end
        end

        if (finalize)
        begin
            ovalid_next = 1'b1;
            odata_next  = {to_off(f_end), to_off(f_start), f_emo, f_found};
            for (int j = 0; j < WD; j++)
            begin
                win_next[j] = 8'h00;
            end
            n_next     = 4'd0;
            pos_next   = '0;
            st_next    = 7'd0;
            ms_next    = '0;
            done_next  = 1'b0;
            emo_next   = etr_pkg::EMO_SMILE;
            end_next   = '0;
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WD; j++)
            begin
                win_reg[j] <= 8'h00;
            end
            n_reg      <= 4'd0;
            pos_reg    <= '0;
            st_reg     <= 7'd0;
            ms_reg     <= '0;
            done_reg   <= 1'b0;
            emo_reg    <= etr_pkg::EMO_SMILE;
            end_reg    <= '0;
            drain_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < WD; j++)
            begin
                win_reg[j] <= win_next[j];
            end
            n_reg      <= n_next;
            pos_reg    <= pos_next;
            st_reg     <= st_next;
            ms_reg     <= ms_next;
            done_reg   <= done_next;
            emo_reg    <= emo_next;
            end_reg    <= end_next;
            drain_reg  <= drain_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

endmodule

### hdl/etr_chk.sv
// ----------------------------------------------------------------------------
// etr_chk: port-level checks for the emoticon token recognizer
// Watches both stream channels and the result fields over time.
// ----------------------------------------------------------------------------
module etr_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tlast,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
            m_axis_tdata[5:1] == 5'd0 && m_axis_tdata[18:6] == m_axis_tdata[31:19])
        else $error("no-match result with inconsistent fields");

    a_emo_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[5:1] <= 5'd25)
        else $error("emotion code out of range");

    // input side closes only after the final byte of a buffer
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
        else $error("input closed without a final beat");

endmodule

bind emoticon_token_recognizer etr_chk u_etr_chk (.*);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: emoticon token recognizer testbench
// Streams text buffers into the recognizer and predicts, in the testbench, the
// first emoticon of each buffer. Each result beat is compared field by field
// with the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAXLEN   = etr_pkg::MAX_LEN_DEF;
    localparam int WDEPTH   = etr_pkg::WIN_DEPTH;
    localparam int KWN      = etr_pkg::KW_COUNT;
    localparam int ACC_BASE = 100;   // table entries at or above this accept
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic [7:0]  s_axis_tdata;    // text_byte[7:0]
    logic        s_axis_tlast;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;    // found, emotion_code, start_offset, end_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready;

    emoticon_token_recognizer dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // transition table: state, class, next (ACC_BASE + emotion on accept)
    int arc_tab[$] = '{
        1,6,ACC_BASE+etr_pkg::EMO_ROLL, 1,24,47, 2,6,38, 2,32,39, 3,31,40,
        9,9,73, 9,12,47, 9,15,49, 11,6,49, 11,15,49,
        12,2,51, 12,3,53, 12,4,54, 12,5,ACC_BASE+etr_pkg::EMO_KISS, 12,6,50, 12,12,55,
        12,15,50, 12,17,ACC_BASE+etr_pkg::EMO_CONFUSE,
        12,22,ACC_BASE+etr_pkg::EMO_NEUTRAL, 12,36,ACC_BASE+etr_pkg::EMO_NEUTRAL,
        13,4,ACC_BASE+etr_pkg::EMO_WINK, 13,6,57, 13,15,57,
        15,2,58, 15,3,ACC_BASE+etr_pkg::EMO_FROWN, 15,5,ACC_BASE+etr_pkg::EMO_KISS,
        15,6,59, 15,17,ACC_BASE+etr_pkg::EMO_CONFUSE, 15,19,60,
        15,22,ACC_BASE+etr_pkg::EMO_NEUTRAL, 15,36,ACC_BASE+etr_pkg::EMO_NEUTRAL,
        16,12,61, 16,15,62, 18,31,65, 19,6,68, 19,15,68, 20,12,69, 20,15,69,
        21,6,71, 22,6,72, 24,32,74, 27,6,75, 29,15,76, 31,31,81, 33,28,82,
        34,32,83, 37,6,84, 37,7,84,
        38,4,ACC_BASE+etr_pkg::EMO_WINK, 39,2,ACC_BASE+etr_pkg::EMO_SHOCK,
        40,15,44, 40,32,41, 41,31,42, 42,14,43, 43,4,ACC_BASE+etr_pkg::EMO_SWEAT,
        44,32,45, 45,15,46, 46,4,ACC_BASE+etr_pkg::EMO_SLEEP,
        47,4,ACC_BASE+etr_pkg::EMO_SAINT, 47,6,48, 48,4,ACC_BASE+etr_pkg::EMO_SAINT,
        49,4,ACC_BASE+etr_pkg::EMO_GLASSES, 49,9,ACC_BASE+etr_pkg::EMO_EEK,
        49,22,ACC_BASE+etr_pkg::EMO_ROLL, 49,24,ACC_BASE+etr_pkg::EMO_EEK,
        50,3,ACC_BASE+etr_pkg::EMO_FROWN, 50,4,ACC_BASE+etr_pkg::EMO_SMILE,
        50,5,ACC_BASE+etr_pkg::EMO_KISS, 50,8,ACC_BASE+etr_pkg::EMO_CONFUSE,
        50,9,ACC_BASE+etr_pkg::EMO_SURPRISE, 50,10,ACC_BASE+etr_pkg::EMO_KITTY,
        50,14,ACC_BASE+etr_pkg::EMO_GRUMPY, 50,17,ACC_BASE+etr_pkg::EMO_CONFUSE,
        50,18,ACC_BASE+etr_pkg::EMO_UPSET, 50,22,ACC_BASE+etr_pkg::EMO_NEUTRAL,
        50,23,ACC_BASE+etr_pkg::EMO_GRUMPY, 50,24,ACC_BASE+etr_pkg::EMO_SURPRISE,
        50,25,ACC_BASE+etr_pkg::EMO_RAZZ, 50,26,ACC_BASE+etr_pkg::EMO_GRUMPY,
        50,34,ACC_BASE+etr_pkg::EMO_SURPRISE, 50,35,ACC_BASE+etr_pkg::EMO_CONFUSE,
        50,36,ACC_BASE+etr_pkg::EMO_NEUTRAL,
        51,3,ACC_BASE+etr_pkg::EMO_CRY, 51,6,52, 52,3,ACC_BASE+etr_pkg::EMO_CRY,
        53,0,ACC_BASE+etr_pkg::EMO_FROWN, 53,3,ACC_BASE+etr_pkg::EMO_CRY,
        54,0,ACC_BASE+etr_pkg::EMO_SMILE, 54,4,ACC_BASE+etr_pkg::EMO_YELL, 55,6,56,
        56,4,ACC_BASE+etr_pkg::EMO_GLASSES,
        57,4,ACC_BASE+etr_pkg::EMO_WINK, 57,21,ACC_BASE+etr_pkg::EMO_WINK,
        57,30,ACC_BASE+etr_pkg::EMO_GRIN, 58,3,ACC_BASE+etr_pkg::EMO_CRY,
        59,3,ACC_BASE+etr_pkg::EMO_FROWN, 59,5,ACC_BASE+etr_pkg::EMO_KISS,
        59,17,ACC_BASE+etr_pkg::EMO_CONFUSE, 59,22,ACC_BASE+etr_pkg::EMO_NEUTRAL,
        59,24,ACC_BASE+etr_pkg::EMO_SURPRISE, 59,25,ACC_BASE+etr_pkg::EMO_RAZZ,
        59,26,ACC_BASE+etr_pkg::EMO_GRUMPY, 59,34,ACC_BASE+etr_pkg::EMO_SURPRISE,
        59,36,ACC_BASE+etr_pkg::EMO_NEUTRAL, 60,4,ACC_BASE+etr_pkg::EMO_COOL,
        61,3,ACC_BASE+etr_pkg::EMO_UPSET, 61,4,ACC_BASE+etr_pkg::EMO_EVIL, 61,6,63,
        61,21,ACC_BASE+etr_pkg::EMO_GLEEFUL,
        62,3,ACC_BASE+etr_pkg::EMO_UPSET, 62,4,ACC_BASE+etr_pkg::EMO_EVIL,
        62,16,ACC_BASE+etr_pkg::EMO_EVIL, 62,21,ACC_BASE+etr_pkg::EMO_EVIL,
        63,3,ACC_BASE+etr_pkg::EMO_UPSET, 63,4,ACC_BASE+etr_pkg::EMO_EVIL, 63,6,64,
        63,21,ACC_BASE+etr_pkg::EMO_EVIL,
        64,3,ACC_BASE+etr_pkg::EMO_UPSET, 64,4,ACC_BASE+etr_pkg::EMO_EVIL,
        64,21,ACC_BASE+etr_pkg::EMO_EVIL,
        65,6,66, 66,31,67, 67,18,ACC_BASE+etr_pkg::EMO_RED,
        68,4,ACC_BASE+etr_pkg::EMO_COOL,
        69,4,ACC_BASE+etr_pkg::EMO_SAINT, 69,6,70, 70,4,ACC_BASE+etr_pkg::EMO_SAINT,
        71,12,ACC_BASE+etr_pkg::EMO_UPSET, 71,15,ACC_BASE+etr_pkg::EMO_UPSET,
        72,4,ACC_BASE+etr_pkg::EMO_SLEEP, 73,9,ACC_BASE+etr_pkg::EMO_EEK,
        74,24,ACC_BASE+etr_pkg::EMO_EEK,
        75,3,ACC_BASE+etr_pkg::EMO_UPSET, 75,21,ACC_BASE+etr_pkg::EMO_YELL,
        76,34,77, 77,6,78, 78,34,79, 79,15,80, 80,8,ACC_BASE+etr_pkg::EMO_GLASSES,
        81,13,ACC_BASE+etr_pkg::EMO_SWEAT, 82,15,ACC_BASE+etr_pkg::EMO_RAZZ,
        83,34,ACC_BASE+etr_pkg::EMO_NEUTRAL, 84,37,ACC_BASE+etr_pkg::EMO_BLINK
    };

    string class_chars = "%'()*-./038:;<=>?@BCDILOPSX[\\]^_cos|~";

    string kw_text [KWN] = '{":angel:", ":cool:", ":grin:", ":lol:", ":neutral:",
        ":oops:", ":wunk:", ":zzz:", ":roll:", ":sad:", ":shock:", ":smile:",
        ":eek:", ":evil:"};
    logic [4:0] kw_emo [KWN] = '{etr_pkg::EMO_SAINT, etr_pkg::EMO_COOL,
        etr_pkg::EMO_GRIN, etr_pkg::EMO_GLEEFUL, etr_pkg::EMO_NEUTRAL,
        etr_pkg::EMO_SURPRISE, etr_pkg::EMO_WINK, etr_pkg::EMO_SLEEP,
        etr_pkg::EMO_ROLL, etr_pkg::EMO_FROWN, etr_pkg::EMO_SHOCK,
        etr_pkg::EMO_SMILE, etr_pkg::EMO_EEK, etr_pkg::EMO_EVIL};

    string frags [30] = '{":)", ":-)", ":(", ":-(", ";)", ";-)", ":D", ":-D", ":P",
        ":-P", "8-)", "B-)", "O:)", ">:)", ":'(", ":o", ":|", "=)", "^_^", "-_-",
        "X-(", "%-)", "|-O", ":-*", ":?", "0:-)", "^^;", "=(", ":')", ":-|"};

    // ---------------- predictor state ----------------
    logic [7:0]  win [WDEPTH];
    logic [8:0]  win_valid;
    int          dfa_st;
    int          cand_start;
    int          byte_pos;
    bit          hit;
    logic [4:0]  hit_emo;
    int          hit_end;

    logic [31:0] pending_results [$];
    int          err_count;
    int          buf_count;
    int          hit_count;

    function automatic int char_class(logic [7:0] b);
        for (int i = 0; i < class_chars.len(); i++)
            if (class_chars[i] == b)
                return i + 1;
        return 0;
    endfunction

    // negative return: accept of emotion -r-1
    function automatic int next_state(int st, int sym);
        if (st == 0)
            return sym;
        for (int i = 0; i < arc_tab.size(); i += 3)
            if (arc_tab[i] == st && arc_tab[i + 1] == sym)
                return (arc_tab[i + 2] >= ACC_BASE) ? -(arc_tab[i + 2] - ACC_BASE) - 1
                                                    : arc_tab[i + 2];
        return 0;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < WDEPTH; i++)
            win[i] = 8'h00;
        win_valid = '0;
        dfa_st = 0;
        cand_start = 0;
        byte_pos = 0;
        hit = 1'b0;
        hit_emo = '0;
        hit_end = 0;
    endtask

    task automatic take_hit(int a, int st, int en);
        hit = 1'b1;
        hit_emo = 5'(-a - 1);
        cand_start = st;
        hit_end = en;
    endtask

    task automatic scan_head(int idx, int avail);
        int sym;
        int nx;
        int hold;
        bit same;
        if (hit)
            return;
        for (int k = 0; k < KWN; k++)
        begin
            if (kw_text[k].len() <= avail)
            begin
                same = 1'b1;
                for (int j = 0; j < kw_text[k].len(); j++)
                    if (win[j] != kw_text[k][j])
                        same = 1'b0;
                if (same)
                begin
                    take_hit(-int'(kw_emo[k]) - 1, idx, idx + kw_text[k].len());
                    return;
                end
            end
        end
        sym = char_class(win[0]);
        hold = next_state(dfa_st, 0);
        if (sym == 0)
        begin
            if (dfa_st > 0 && hold < 0)
                take_hit(hold, cand_start, idx);
            else
                dfa_st = 0;
            return;
        end
        nx = next_state(dfa_st, sym);
        if (nx < 0)
        begin
            take_hit(nx, cand_start, idx + 1);
            return;
        end
        if (nx > 0)
        begin
            if (dfa_st == 0)
                cand_start = idx;
        end
        else if (dfa_st > 0 && hold < 0)
        begin
            take_hit(hold, cand_start, idx);
            return;
        end
        dfa_st = nx;
    endtask

    task automatic shift_window();
        for (int i = 0; i < WDEPTH - 1; i++)
            win[i] = win[i + 1];
        win[WDEPTH - 1] = 8'h00;
        win_valid = win_valid >> 1;
    endtask

    task automatic scan_byte(logic [7:0] b, bit last);
        int n;
        int hold;
        logic [31:0] res;
        n = 0;
        while (n < WDEPTH && win_valid[n])
            n++;
        if (byte_pos < MAXLEN && n < WDEPTH)
        begin
            win[n] = b;
            win_valid[n] = 1'b1;
            byte_pos++;
            n++;
        end
        if (!last)
        begin
            if (n == WDEPTH)
            begin
                scan_head(byte_pos - WDEPTH, WDEPTH);
                shift_window();
            end
            return;
        end
        while (n > 0)
        begin
            scan_head(byte_pos - n, n);
            shift_window();
            n--;
        end
        hold = next_state(dfa_st, 0);
        if (!hit && dfa_st > 0 && hold < 0)
            take_hit(hold, cand_start, byte_pos);
        if (hit)
            res = {13'(hit_end), 13'(cand_start), hit_emo, 1'b1};
        else
            res = {13'(byte_pos), 13'(byte_pos), 5'd0, 1'b0};
        hit_count += hit;
        buf_count++;
        pending_results.push_back(res);
        clear_scan();
    endtask

    // ---------------- stimulus ----------------
    logic [8:0] text_beats [$];   // {last, byte}

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_beats.push_back({1'(i == s.len() - 1), 8'(s[i])});
    endtask

    task automatic push_random_buffer();
        logic [7:0] bytes [$];
        int parts;
        int r;
        int ci;
        string f;
        parts = $urandom_range(1, 5);
        for (int p = 0; p < parts; p++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                f = frags[$urandom_range(0, 29)];
            else if (r < 6)
            begin
                f = kw_text[$urandom_range(0, KWN - 1)];
                // sometimes break the keyword
                if ($urandom_range(0, 3) == 0)
                    f = f.substr(0, $urandom_range(0, f.len() - 2));
            end
            else if (r < 8)
            begin
                ci = $urandom_range(0, class_chars.len() - 1);
                f = class_chars.substr(ci, ci);
            end
            else
                f = "";
            for (int i = 0; i < f.len(); i++)
                bytes.push_back(f[i]);
            if (r >= 8 || $urandom_range(0, 2) == 0)
                bytes.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < bytes.size(); i++)
            text_beats.push_back({1'(i == bytes.size() - 1), bytes[i]});
    endtask

    initial
    begin
        err_count = 0;
        buf_count = 0;
        hit_count = 0;
        clear_scan();
        push_text(":smile:");
        push_text("x:-)");
        push_text(":(");
        push_text("zz:ruzz:");
        push_text(":smile");
        push_text("8-)q");
        text_beats.push_back({1'b0, 8'hFF});
        text_beats.push_back({1'b1, 8'h00});
        push_text(":neutral:");
        while (text_beats.size() < 1650)
            push_random_buffer();
    end

    // ---------------- reset, driver, monitor ----------------
    bit in_fire;
    bit out_fire;
    int gap_left;
    int stall_left;
    int beat_count;
    bit burst;
    longint cycles;

    initial
    begin
        rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        gap_left = 0;
        stall_left = 0;
        beat_count = 0;
        burst = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("tb: mismatch %s: got %0d want %0d (buffer %0d)", what, got, want,
                 buf_count);
    endtask

    always @(posedge clk)
    begin
        logic [31:0] want;
        in_fire = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
        if (in_fire)
            scan_byte(s_axis_tdata, s_axis_tlast);
        if (out_fire)
        begin
            if (pending_results.size() == 0)
                report("unexpected beat", m_axis_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] != want[0])
                    report("found", m_axis_tdata[0], want[0]);
                if (m_axis_tdata[5:1] != want[5:1])
                    report("emotion_code", m_axis_tdata[5:1], want[5:1]);
                if (m_axis_tdata[18:6] != want[18:6])
                    report("start_offset", m_axis_tdata[18:6], want[18:6]);
                if (m_axis_tdata[31:19] != want[31:19])
                    report("end_offset", m_axis_tdata[31:19], want[31:19]);
            end
        end
    end

    always @(negedge clk)
    begin
        logic [8:0] beat;
        if (rst_n)
        begin
            if (in_fire || !s_axis_tvalid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid = 1'b0;
                end
                else if (text_beats.size() > 0)
                begin
                    beat = text_beats.pop_front();
                    s_axis_tdata = beat[7:0];
                    s_axis_tlast = beat[8];
                    s_axis_tvalid = 1'b1;
                    beat_count++;
                    // alternate between idle-free stretches and random gaps
                    if (beat_count % 300 == 0)
                        burst = !burst;
                    gap_left = burst ? 0 : $urandom_range(0, 15);
                end
                else
                    s_axis_tvalid = 1'b0;
            end
            if (out_fire)
                stall_left = burst ? 0 : $urandom_range(0, 15);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
            in_fire = 1'b0;
            out_fire = 1'b0;
        end
    end

    // ---------------- end of run ----------------
    initial
    begin
        cycles = 0;
        @(posedge rst_n);
        while ((text_beats.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
               && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
        end
        else
        begin
            repeat (40) @(posedge clk);
            $display("tb: %0d buffers in %0d beats, %0d with an emoticon",
                     buf_count, beat_count, hit_count);
            if (err_count == 0 && pending_results.size() == 0)
                $display("tb: clean");
            else
                $display("tb: errors");
        end
        $finish;
    end
endmodule

### emoticon_token_recognizer.f
hdl/etr_pkg.sv
hdl/etr_scan.sv
hdl/emoticon_token_recognizer.sv
hdl/etr_chk.sv
sim/tb.sv
